/* src/rrs_pkg.sv */
// Shared types and constants of the round-robin CPU/I/O scheduler.
package rrs_pkg;

  // Scheduler sizes. The job and phase counts are tied to the fixed stream
  // field widths below; only the stored length width is a top-level parameter.
  localparam int MAX_JOBS        = 4;
  localparam int PHASES          = 5;
  localparam int LENGTH_BITS_DEF = 8;

  // Fixed field widths of the stream items.
  localparam int CMD_W      = 2;
  localparam int JOB_W      = 2;
  localparam int PHASE_W    = 3;
  localparam int LEN_IN_W   = 8;
  localparam int COUNT_W    = 16;
  localparam int QUANTUM_W  = 8;
  localparam int ACTIVE_W   = 3;
  localparam int CFG_DATA_W = 8;

  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic {
    CFG_QUANTUM     = 1'b0,
    CFG_ACTIVE_JOBS = 1'b1
  } cfg_index_t;

  // One result item as the core hands it to the output register.
  typedef struct packed {
    logic               all_done;
    logic [COUNT_W-1:0] idle_ticks;
    logic [COUNT_W-1:0] tick_count;
    logic [JOB_W-1:0]   finished_job;
    logic               job_finished;
    logic [JOB_W-1:0]   io_job;
    logic               io_busy;
    logic [JOB_W-1:0]   cpu_job;
    logic               cpu_busy;
  } rrs_result_t;

endpackage

/* src/round_robin_cpu_io_scheduler.sv */
// Top level: configuration registers, the scheduler core and the result register.
//
//   Channel  Direction  Transfer when            Payload
//   in_      slave      in_tvalid & in_tready    cmd, job_index, phase_index, phase_length
//   out_     master     out_tvalid & out_tready  busy flags, job indexes, counters, all_done
//   cfg_     slave      cfg_valid & cfg_ready    register index, write data
//
// The core updates its state at the input transfer, and the result is held in the
// output register from the next cycle on.
// A new item is taken in the same cycle as the waiting result leaves, so one item per
// cycle is sustained; a stalled output holds in_tready low until it drains.
// Reset is synchronous on rst_n and clears the queues, positions, counters and the
// output valid; the phase lengths must be loaded before they are used.
module round_robin_cpu_io_scheduler #(
  parameter int LENGTH_BITS = rrs_pkg::LENGTH_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // cmd[1:0], job_index[3:2], phase_index[6:4], phase_length[14:7], zero[15]
  input  logic [rrs_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // cpu_busy[0], cpu_job[2:1], io_busy[3], io_job[5:4], job_finished[6],
  // finished_job[8:7], tick_count[24:9], idle_ticks[40:25], all_done[41], zero[47:42]
  output logic [rrs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [rrs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import rrs_pkg::*;

  logic [QUANTUM_W-1:0] quantum_r;
  logic [ACTIVE_W-1:0]  active_jobs_r;
  logic                 out_valid_r;
  rrs_result_t          result_r;
  rrs_result_t          result;
  logic                 in_xfer;

  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  rrs_core #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (in_xfer),
    .cmd          (in_tdata[1:0]),
    .job_index    (in_tdata[3:2]),
    .phase_index  (in_tdata[6:4]),
    .phase_length (in_tdata[14:7]),
    .quantum      (quantum_r),
    .active_jobs  (active_jobs_r),
    .result       (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r     <= QUANTUM_W'(4);
      active_jobs_r <= ACTIVE_W'(3);
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index_t'(cfg_index))
          CFG_QUANTUM:     quantum_r     <= cfg_data[QUANTUM_W-1:0];
          CFG_ACTIVE_JOBS: active_jobs_r <= cfg_data[ACTIVE_W-1:0];
          default: begin
          end
        endcase
      end
      if (in_xfer) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      result_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - $bits(rrs_result_t)){1'b0}}, result_r};

endmodule

/* src/rrs_core.sv */
// Scheduler state and its single-pass update for one command item.
module rrs_core #(
  parameter int LENGTH_BITS = rrs_pkg::LENGTH_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  input  logic [rrs_pkg::CMD_W-1:0]       cmd,
  input  logic [rrs_pkg::JOB_W-1:0]       job_index,
  input  logic [rrs_pkg::PHASE_W-1:0]     phase_index,
  input  logic [rrs_pkg::LEN_IN_W-1:0]    phase_length,
  input  logic [rrs_pkg::QUANTUM_W-1:0]   quantum,
  input  logic [rrs_pkg::ACTIVE_W-1:0]    active_jobs,
  output rrs_pkg::rrs_result_t            result
);
  import rrs_pkg::*;

  localparam int JW  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW  = $clog2(MAX_JOBS + 1);
  localparam int CW1 = CW + 1;
  localparam int PW  = $clog2(PHASES + 1);
  localparam int PIW = $clog2(PHASES);
  localparam int LW  = LENGTH_BITS;

  logic [LW-1:0]        phase_r   [MAX_JOBS][PHASES];
  logic [LW-1:0]        phase_nxt [MAX_JOBS][PHASES];
  logic [PW-1:0]        pos_r     [MAX_JOBS];
  logic [PW-1:0]        pos_nxt   [MAX_JOBS];
  logic [JW-1:0]        rring_r   [MAX_JOBS];
  logic [JW-1:0]        rring_nxt [MAX_JOBS];
  logic [JW-1:0]        wring_r   [MAX_JOBS];
  logic [JW-1:0]        wring_nxt [MAX_JOBS];
  logic [JW-1:0]        rhead_r, rhead_nxt, whead_r, whead_nxt;
  logic [CW-1:0]        rcount_r, rcount_nxt, wcount_r, wcount_nxt;
  logic [QUANTUM_W-1:0] qleft_r, qleft_nxt;
  logic [COUNT_W-1:0]   tick_r, tick_nxt, idle_r, idle_nxt;

  // Per-job lane status of the phase the job is in.
  logic [MAX_JOBS-1:0]  lane_end;
  logic [MAX_JOBS-1:0]  lane_more;
  logic [LW-1:0]        lane_val  [MAX_JOBS];

  logic [JW-1:0]        cpu_j, io_j;
  logic                 ready_start, wait_busy, run;
  logic                 cpu_end, cpu_more, io_end;
  logic [QUANTUM_W-1:0] eff_q;
  cmd_t                 cmd_e;

  function automatic logic [JW-1:0] ring_tail(logic [JW-1:0] h, logic [CW-1:0] c);
    logic [CW1-1:0] s;
    s = CW1'(h) + CW1'(c);
    if (s >= CW1'(MAX_JOBS)) begin
      s = s - CW1'(MAX_JOBS);
    end
    return JW'(s);
  endfunction

  function automatic logic [JW-1:0] ring_next(logic [JW-1:0] h);
    logic [JW:0] s;
    s = (JW + 1)'(h) + (JW + 1)'(1);
    return (s >= (JW + 1)'(MAX_JOBS)) ? '0 : JW'(s);
  endfunction

  assign cmd_e       = cmd_t'(cmd);
  assign cpu_j       = rring_r[rhead_r];
  assign io_j        = wring_r[whead_r];
  assign ready_start = (rcount_r != '0);
  assign wait_busy   = (wcount_r != '0);
  assign run         = item_valid && (cmd_e == CMD_TICK) && (ready_start || wait_busy);
  assign eff_q       = (quantum == '0) ? QUANTUM_W'(1) : quantum;

  // Every job lane looks at its own current phase and the slot after it.
  always_comb begin
    for (int j = 0; j < MAX_JOBS; j++) begin
      lane_val[j]  = (pos_r[j] < PW'(PHASES)) ? phase_r[j][pos_r[j][PIW-1:0]] : '0;
      lane_end[j]  = (lane_val[j] <= LW'(1));
      lane_more[j] = (32'(pos_r[j]) + 2 < PHASES) &&
                     (phase_r[j][PIW'(pos_r[j] + PW'(1))] != '0);
    end
  end

  assign cpu_end  = lane_end[cpu_j];
  assign cpu_more = lane_more[cpu_j];
  assign io_end   = lane_end[io_j];

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    rring_nxt  = rring_r;
    wring_nxt  = wring_r;
    rhead_nxt  = rhead_r;
    whead_nxt  = whead_r;
    rcount_nxt = rcount_r;
    wcount_nxt = wcount_r;
    qleft_nxt  = qleft_r;
    tick_nxt   = tick_r;
    idle_nxt   = idle_r;

    if (item_valid) begin
      unique case (cmd_e)
        CMD_LOAD: begin
          if ((32'(job_index) < MAX_JOBS) && (32'(phase_index) < PHASES)) begin
            phase_nxt[JW'(job_index)][PIW'(phase_index)] = LW'(phase_length);
          end
        end
        CMD_START: begin
          rhead_nxt  = '0;
          whead_nxt  = '0;
          wcount_nxt = '0;
          rcount_nxt = (32'(active_jobs) > MAX_JOBS) ? CW'(MAX_JOBS) : CW'(active_jobs);
          for (int j = 0; j < MAX_JOBS; j++) begin
            pos_nxt[j] = '0;
            if (32'(j) < 32'(active_jobs)) begin
              rring_nxt[j] = JW'(j);
            end
          end
          qleft_nxt = eff_q;
          tick_nxt  = '0;
          idle_nxt  = '0;
        end
        CMD_TICK: begin
          if (run) begin
            if (tick_r != '1) begin
              tick_nxt = tick_r + COUNT_W'(1);
            end
            // I/O head first; a finished I/O period joins the ready tail.
            if (wait_busy) begin
              if (io_end) begin
                if (pos_r[io_j] < PW'(PHASES)) begin
                  phase_nxt[io_j][pos_r[io_j][PIW-1:0]] = '0;
                end
                pos_nxt[io_j] = pos_r[io_j] + PW'(1);
                whead_nxt     = ring_next(whead_r);
                wcount_nxt    = wcount_r - CW'(1);
                if (rcount_nxt < CW'(MAX_JOBS)) begin
                  rring_nxt[ring_tail(rhead_nxt, rcount_nxt)] = io_j;
                  rcount_nxt = rcount_nxt + CW'(1);
                end
              end else begin
                phase_nxt[io_j][pos_r[io_j][PIW-1:0]] = lane_val[io_j] - LW'(1);
              end
            end
            if (ready_start) begin
              if (cpu_end) begin
                if (pos_r[cpu_j] < PW'(PHASES)) begin
                  phase_nxt[cpu_j][pos_r[cpu_j][PIW-1:0]] = '0;
                end
                rhead_nxt  = ring_next(rhead_r);
                rcount_nxt = rcount_nxt - CW'(1);
                if (cpu_more) begin
                  pos_nxt[cpu_j] = pos_r[cpu_j] + PW'(1);
                  if (wcount_nxt < CW'(MAX_JOBS)) begin
                    wring_nxt[ring_tail(whead_nxt, wcount_nxt)] = cpu_j;
                    wcount_nxt = wcount_nxt + CW'(1);
                  end
                end
                qleft_nxt = eff_q;
              end else begin
                phase_nxt[cpu_j][pos_r[cpu_j][PIW-1:0]] = lane_val[cpu_j] - LW'(1);
                if (qleft_r <= QUANTUM_W'(1)) begin
                  // Slice used up: the running job goes behind everything queued.
                  rhead_nxt  = ring_next(rhead_r);
                  rcount_nxt = rcount_nxt - CW'(1);
                  if (rcount_nxt < CW'(MAX_JOBS)) begin
                    rring_nxt[ring_tail(rhead_nxt, rcount_nxt)] = cpu_j;
                    rcount_nxt = rcount_nxt + CW'(1);
                  end
                  qleft_nxt = eff_q;
                end else begin
                  qleft_nxt = qleft_r - QUANTUM_W'(1);
                end
              end
            end else begin
              if (idle_r != '1) begin
                idle_nxt = idle_r + COUNT_W'(1);
              end
              qleft_nxt = eff_q;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result.cpu_busy     = run && ready_start;
    result.cpu_job      = (run && ready_start) ? JOB_W'(cpu_j) : '0;
    result.io_busy      = run && wait_busy;
    result.io_job       = (run && wait_busy) ? JOB_W'(io_j) : '0;
    result.job_finished = run && ready_start && cpu_end && !cpu_more;
    result.finished_job = (run && ready_start && cpu_end && !cpu_more) ? JOB_W'(cpu_j) : '0;
    result.tick_count   = tick_nxt;
    result.idle_ticks   = idle_nxt;
    result.all_done     = (rcount_nxt == '0) && (wcount_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '{default: '0};
      rhead_r  <= '0;
      whead_r  <= '0;
      rcount_r <= '0;
      wcount_r <= '0;
      qleft_r  <= '0;
      tick_r   <= '0;
      idle_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      rhead_r  <= rhead_nxt;
      whead_r  <= whead_nxt;
      rcount_r <= rcount_nxt;
      wcount_r <= wcount_nxt;
      qleft_r  <= qleft_nxt;
      tick_r   <= tick_nxt;
      idle_r   <= idle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    rring_r <= rring_nxt;
    wring_r <= wring_nxt;
  end

endmodule

/* dv/tb.sv */
// Self-checking testbench for the round-robin CPU/I/O scheduler stream block.
`timescale 1ns / 1ps

module tb;
  import rrs_pkg::*;

  localparam int NJOBS = MAX_JOBS;
  localparam int NPH   = PHASES;
  localparam logic [CMD_W-1:0] CMD_BAD = 2'd3;

  localparam rrs_result_t RES_DONE  = '{all_done: 1'b1, default: '0};
  localparam rrs_result_t RES_FRESH = '0;

  typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HALF, RX_CHOKED} rx_mode_t;

  typedef struct packed {
    logic             is_cfg;
    cfg_index_t       sel;
    logic [CMD_W-1:0] cmd;
    logic [JOB_W-1:0] job;
    logic [PHASE_W-1:0] phase;
    logic [7:0]       value;
    logic             typed;
    rrs_result_t      want;
  } plan_row_t;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  cfg_index_t             cfg_index  = CFG_QUANTUM;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  round_robin_cpu_io_scheduler dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("FAILURE");
    $finish;
  end

  // Scheduler state as the testbench tracks it.
  logic [7:0]       m_len [NJOBS][NPH];
  logic [2:0]       m_pos [NJOBS] = '{default: '0};
  logic [JOB_W-1:0] m_rdy [NJOBS];
  logic [JOB_W-1:0] m_wt  [NJOBS];
  int               m_rdy_head = 0, m_rdy_cnt = 0, m_wt_head = 0, m_wt_cnt = 0;
  logic [7:0]       m_qleft   = '0;
  logic [15:0]      m_ticks   = '0;
  logic [15:0]      m_idles   = '0;
  logic [7:0]       m_quantum = 8'd4;
  logic [2:0]       m_active  = 3'd3;

  rrs_result_t expected_status[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          burst_left = 0;
  plan_row_t   plan_rows[$];

  function automatic logic [7:0] slice_length();
    return (m_quantum == 8'd0) ? 8'd1 : m_quantum;
  endfunction

  function automatic void ready_push(logic [JOB_W-1:0] j);
    if (m_rdy_cnt < NJOBS) begin
      m_rdy[(m_rdy_head + m_rdy_cnt) % NJOBS] = j;
      m_rdy_cnt++;
    end
  endfunction

  function automatic bit schedule_empty();
    return m_rdy_cnt == 0 && m_wt_cnt == 0;
  endfunction

  // Advances the tracked state by one command and returns the status it reports.
  function automatic rrs_result_t predict_schedule_step(logic [CMD_W-1:0] cmd,
      logic [JOB_W-1:0] job, logic [PHASE_W-1:0] ph, logic [7:0] len);
    rrs_result_t      r;
    logic             had_ready;
    logic             last_burst;
    logic [JOB_W-1:0] j;
    logic [7:0]       v;
    int               p;
    int               n;
    int               i;
    r = '0;
    unique case (cmd)
      CMD_LOAD: begin
        if (ph < NPH) m_len[job][ph] = len;
      end
      CMD_START: begin
        m_rdy_head = 0;
        m_rdy_cnt  = 0;
        m_wt_head  = 0;
        m_wt_cnt   = 0;
        for (i = 0; i < NJOBS; i++) m_pos[i] = '0;
        n = (m_active > NJOBS) ? NJOBS : int'(m_active);
        for (i = 0; i < n; i++) ready_push(JOB_W'(i));
        m_qleft = slice_length();
        m_ticks = '0;
        m_idles = '0;
      end
      CMD_TICK: begin
        had_ready = m_rdy_cnt > 0;
        if (had_ready || m_wt_cnt > 0) begin
          if (m_ticks != 16'hFFFF) m_ticks++;
          // The I/O side moves first, so a job leaving I/O lands ahead of a running job whose slice runs out.
          if (m_wt_cnt > 0) begin
            j = m_wt[m_wt_head];
            r.io_busy = 1'b1;
            r.io_job  = j;
            p = int'(m_pos[j]);
            v = (p < NPH) ? m_len[j][p] : 8'd0;
            if (v <= 8'd1) begin
              if (p < NPH) m_len[j][p] = 8'd0;
              m_pos[j]  = 3'(p + 1);
              m_wt_head = (m_wt_head + 1) % NJOBS;
              m_wt_cnt--;
              ready_push(j);
            end else begin
              m_len[j][p] = v - 8'd1;
            end
          end
          if (had_ready) begin
            j = m_rdy[m_rdy_head];
            r.cpu_busy = 1'b1;
            r.cpu_job  = j;
            p = int'(m_pos[j]);
            v = (p < NPH) ? m_len[j][p] : 8'd0;
            if (v <= 8'd1) begin
              if (p < NPH) m_len[j][p] = 8'd0;
              m_rdy_head = (m_rdy_head + 1) % NJOBS;
              m_rdy_cnt--;
              if (p + 2 >= NPH) last_burst = 1'b1;
              else last_burst = (m_len[j][p + 1] == 8'd0);
              if (last_burst) begin
                r.job_finished = 1'b1;
                r.finished_job = j;
              end else begin
                m_pos[j] = 3'(p + 1);
                if (m_wt_cnt < NJOBS) begin
                  m_wt[(m_wt_head + m_wt_cnt) % NJOBS] = j;
                  m_wt_cnt++;
                end
              end
              m_qleft = slice_length();
            end else begin
              m_len[j][p] = v - 8'd1;
              if (m_qleft <= 8'd1) begin
                m_rdy_head = (m_rdy_head + 1) % NJOBS;
                m_rdy_cnt--;
                ready_push(j);
                m_qleft = slice_length();
              end else begin
                m_qleft = m_qleft - 8'd1;
              end
            end
          end else begin
            if (m_idles != 16'hFFFF) m_idles++;
            m_qleft = slice_length();
          end
        end
      end
      default: ;
    endcase
    r.tick_count = m_ticks;
    r.idle_ticks = m_idles;
    r.all_done   = schedule_empty();
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps, some without a gap.
  task automatic send_item(logic [CMD_W-1:0] cmd, logic [JOB_W-1:0] job,
      logic [PHASE_W-1:0] ph, logic [7:0] len, bit typed, rrs_result_t want);
    int          gap;
    rrs_result_t predicted;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 4));
      burst_left = $urandom_range(1, 16);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, len, ph, job, cmd};
    do @(posedge clk); while (!in_tready);
    predicted = predict_schedule_step(cmd, job, ph, len);
    expected_status.push_back(typed ? want : predicted);
    items_sent++;
  endtask

  task automatic issue(logic [CMD_W-1:0] cmd, logic [JOB_W-1:0] job,
      logic [PHASE_W-1:0] ph, logic [7:0] len);
    send_item(cmd, job, ph, len, 1'b0, '0);
  endtask

  task automatic issue_tick();
    issue(CMD_TICK, JOB_W'($urandom), PHASE_W'($urandom), 8'($urandom));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_index_t sel, logic [7:0] val);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (sel == CFG_QUANTUM) m_quantum = val;
    else m_active = val[2:0];
  endtask

  function automatic plan_row_t item_row(logic [CMD_W-1:0] c, logic [JOB_W-1:0] j,
      logic [PHASE_W-1:0] p, logic [7:0] v);
    plan_row_t row;
    row = '0;
    row.cmd   = c;
    row.job   = j;
    row.phase = p;
    row.value = v;
    return row;
  endfunction

  function automatic plan_row_t known_row(logic [CMD_W-1:0] c, logic [JOB_W-1:0] j,
      logic [PHASE_W-1:0] p, logic [7:0] v, rrs_result_t want);
    plan_row_t row;
    row = item_row(c, j, p, v);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic plan_row_t cfg_row(cfg_index_t sel, logic [7:0] v);
    plan_row_t row;
    row = '0;
    row.is_cfg = 1'b1;
    row.sel    = sel;
    row.value  = v;
    return row;
  endfunction

  function automatic logic [7:0] pick_length();
    int k;
    k = $urandom_range(0, 99);
    if (k < 88) return 8'($urandom_range(0, 5));
    if (k < 98) return 8'($urandom_range(6, 30));
    return 8'($urandom_range(200, 255));
  endfunction

  function automatic logic [7:0] pick_quantum();
    int k;
    k = $urandom_range(0, 99);
    if (k < 10) return 8'd0;
    if (k < 20) return 8'd255;
    if (k < 30) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, 6));
  endfunction

  function automatic logic [7:0] pick_active();
    if ($urandom_range(0, 9) < 7) return 8'($urandom_range(1, 4));
    return 8'($urandom_range(0, 7));
  endfunction

  // Receiver: the stall pattern is picked anew at random each time the low bits of rx_cycle wrap to zero.
  logic [15:0] rx_cycle = '0;
  rx_mode_t    rx_mode  = RX_OPEN;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 16'd1;
    if (rx_cycle[6:0] == 7'd0) rx_mode <= rx_mode_t'($urandom_range(0, 3));
    unique case (rx_mode)
      RX_OPEN:  out_tready <= 1'b1;
      RX_LIGHT: out_tready <= ($urandom_range(0, 3) != 0);
      RX_HALF:  out_tready <= ($urandom_range(0, 1) != 0);
      default:  out_tready <= (rx_cycle % 6 == 0);
    endcase
  end

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatches++;
      if (mismatches <= 100)
        $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    rrs_result_t got;
    rrs_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = rrs_result_t'(out_tdata[$bits(rrs_result_t)-1:0]);
      if (expected_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 100)
          $display("%0t: result expected none, actual %h", $time, got);
      end else begin
        want = expected_status.pop_front();
        check_field("cpu_busy", want.cpu_busy, got.cpu_busy);
        check_field("cpu_job", want.cpu_job, got.cpu_job);
        check_field("io_busy", want.io_busy, got.io_busy);
        check_field("io_job", want.io_job, got.io_job);
        check_field("job_finished", want.job_finished, got.job_finished);
        check_field("finished_job", want.finished_job, got.finished_job);
        check_field("tick_count", want.tick_count, got.tick_count);
        check_field("idle_ticks", want.idle_ticks, got.idle_ticks);
        check_field("all_done", want.all_done, got.all_done);
      end
    end
  end

  initial begin
    int rand_goal;
    int guard;
    int n;
    int k;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every phase slot gets a length before any tick can read it.
    for (int j = 0; j < NJOBS; j++)
      for (int p = 0; p < NPH; p++)
        issue(CMD_LOAD, JOB_W'(j), PHASE_W'(p), 8'($urandom_range(0, 4)));

    plan_rows.push_back(known_row(CMD_TICK, 2'd0, 3'd0, 8'd0, RES_DONE));
    plan_rows.push_back(known_row(CMD_BAD, 2'd3, 3'd7, 8'd255, RES_DONE));
    plan_rows.push_back(known_row(CMD_LOAD, 2'd0, 3'd5, 8'd255, RES_DONE));
    plan_rows.push_back(known_row(CMD_LOAD, 2'd3, 3'd7, 8'hAA, RES_DONE));
    plan_rows.push_back(known_row(CMD_LOAD, 2'd2, 3'd6, 8'h55, RES_DONE));
    plan_rows.push_back(cfg_row(CFG_QUANTUM, 8'd0));
    plan_rows.push_back(cfg_row(CFG_ACTIVE_JOBS, 8'd7));
    plan_rows.push_back(known_row(CMD_LOAD, 2'd0, 3'd0, 8'd0, RES_DONE));
    plan_rows.push_back(known_row(CMD_LOAD, 2'd0, 3'd1, 8'd1, RES_DONE));
    plan_rows.push_back(known_row(CMD_LOAD, 2'd3, 3'd0, 8'd3, RES_DONE));
    plan_rows.push_back(known_row(CMD_LOAD, 2'd3, 3'd4, 8'd255, RES_DONE));
    plan_rows.push_back(known_row(CMD_START, 2'd0, 3'd0, 8'd0, RES_FRESH));
    for (int i = 0; i < 8; i++) plan_rows.push_back(item_row(CMD_TICK, 2'd0, 3'd0, 8'd0));
    plan_rows.push_back(item_row(CMD_BAD, 2'd0, 3'd0, 8'd0));
    plan_rows.push_back(item_row(CMD_LOAD, 2'd1, 3'd0, 8'd85));
    plan_rows.push_back(item_row(CMD_TICK, 2'd0, 3'd0, 8'd0));
    plan_rows.push_back(known_row(CMD_START, 2'd0, 3'd0, 8'd0, RES_FRESH));
    plan_rows.push_back(cfg_row(CFG_ACTIVE_JOBS, 8'd0));
    plan_rows.push_back(known_row(CMD_START, 2'd0, 3'd0, 8'd0, RES_DONE));
    plan_rows.push_back(known_row(CMD_TICK, 2'd0, 3'd0, 8'd0, RES_DONE));
    plan_rows.push_back(cfg_row(CFG_QUANTUM, 8'd255));
    plan_rows.push_back(cfg_row(CFG_ACTIVE_JOBS, 8'd1));

    foreach (plan_rows[i]) begin
      if (plan_rows[i].is_cfg)
        write_cfg(plan_rows[i].sel, plan_rows[i].value);
      else
        send_item(plan_rows[i].cmd, plan_rows[i].job, plan_rows[i].phase,
                  plan_rows[i].value, plan_rows[i].typed, plan_rows[i].want);
    end
    drain_results();

    // Random schedules: load, start, tick until both queues are empty, with some noise.
    rand_goal = items_sent + 1150;
    while (items_sent < rand_goal) begin
      if ($urandom_range(0, 2) == 0) write_cfg(CFG_QUANTUM, pick_quantum());
      if ($urandom_range(0, 2) == 0) write_cfg(CFG_ACTIVE_JOBS, pick_active());
      n = ($urandom_range(0, 4) == 0) ? NJOBS : ((m_active > NJOBS) ? NJOBS : int'(m_active));
      for (int j = 0; j < n; j++)
        for (int p = 0; p < NPH; p++)
          if ($urandom_range(0, 9) != 0) issue(CMD_LOAD, JOB_W'(j), PHASE_W'(p), pick_length());
      if ($urandom_range(0, 9) == 0)
        issue(CMD_LOAD, JOB_W'($urandom), PHASE_W'($urandom_range(5, 7)), 8'($urandom));
      issue(CMD_START, JOB_W'($urandom), PHASE_W'($urandom), 8'($urandom));
      guard = 0;
      while (!schedule_empty() && guard < 4000) begin
        k = $urandom_range(0, 99);
        if (k < 2)
          issue(CMD_BAD, JOB_W'($urandom), PHASE_W'($urandom), 8'($urandom));
        else if (k < 4)
          issue(CMD_LOAD, JOB_W'($urandom), PHASE_W'($urandom_range(0, 4)),
                8'($urandom_range(0, 4)));
        else if (k == 4)
          issue(CMD_START, 2'd0, 3'd0, 8'd0);
        else
          issue_tick();
        guard++;
      end
      repeat ($urandom_range(0, 2)) issue_tick();
    end

    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/rrs_pkg.sv
src/rrs_core.sv
src/round_robin_cpu_io_scheduler.sv
dv/tb.sv
